>>> design/baa_pkg.sv
// ============================================================================
// Binary angle arctangent package
// Widths, the tangent table and the shared types of the arctangent pipeline.
// ============================================================================
package baa_pkg;

    localparam int OFFSET_W    = 19;
    localparam int MAG_W       = 19;
    localparam int REM_W       = MAG_W + 1;
    localparam int RATIO_W     = 14;
    localparam int ANGLE_W     = 8;
    localparam int TAN_ENTRIES = 33;
    localparam int K_W         = 6;
    localparam int DIV_STAGES  = RATIO_W;
    localparam int CMP_GROUPS  = 4;
    localparam int GROUP_SIZE  = (TAN_ENTRIES - 1) / CMP_GROUPS;
    localparam int GROUP_CNT_W = 4;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 8;

    localparam logic [ANGLE_W-1:0] ANGLE_POS_X = 8'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_POS_Y = 8'd64;
    localparam logic [ANGLE_W-1:0] ANGLE_NEG_X = 8'd128;
    localparam logic [ANGLE_W-1:0] ANGLE_NEG_Y = 8'd192;

    // tan(k * 2pi / 256) in Q1.13, truncated.
    localparam logic [RATIO_W-1:0] TAN_ROM [TAN_ENTRIES] = '{
        14'd0,    14'd201,  14'd402,  14'd604,  14'd806,  14'd1010, 14'd1215, 14'd1421,
        14'd1629, 14'd1839, 14'd2051, 14'd2267, 14'd2485, 14'd2706, 14'd2931, 14'd3160,
        14'd3393, 14'd3631, 14'd3874, 14'd4123, 14'd4378, 14'd4640, 14'd4910, 14'd5187,
        14'd5473, 14'd5769, 14'd6075, 14'd6393, 14'd6723, 14'd7066, 14'd7424, 14'd7799,
        14'd8192
    };

    // How the table index becomes the final angle.
    typedef struct packed {
        logic               bypass;
        logic [ANGLE_W-1:0] fixed_angle;
        logic [ANGLE_W-1:0] base;
        logic               subtract;
    } map_t;

endpackage

>>> design/binary_angle_arctangent.sv
// Throughput: one beat per cycle unless m_tready holds the output beat; the
// 14-stage restoring divider produces one quotient bit per stage, and the
// whole pipeline advances together.
// When the output beat is held by m_tready low, every stage holds its contents.
// Reset (aresetn low, synchronous) clears all stage valid bits; data registers
// are not reset.
// ============================================================================
// Binary angle arctangent
// Returns the 8-bit binary angle of (-x_offset, -y_offset) by octant folding,
// a pipelined Q1.13 ratio division and a tangent table search.
// ============================================================================
module binary_angle_arctangent (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0 up: x_offset[18:0], y_offset[18:0], default_angle[7:0], zero pad[1:0].
    input  logic [baa_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0 up: angle[7:0].
    output logic [baa_pkg::M_TDATA_W-1:0]  m_tdata
);

    // The entire pipeline moves as one; a held output beat stalls every stage.
    logic advance;

    // ------------------------------------------------------------------
    // Front stage: fold the vector into an octant.
    // ------------------------------------------------------------------
    logic signed [baa_pkg::OFFSET_W-1:0] x_in;
    logic signed [baa_pkg::OFFSET_W-1:0] y_in;
    logic [baa_pkg::ANGLE_W-1:0]         default_in;
    logic [baa_pkg::MAG_W-1:0]           ax;
    logic [baa_pkg::MAG_W-1:0]           ay;
    logic                                x_zero;
    logic                                y_zero;
    logic                                x_neg;
    logic                                y_neg;
    logic                                swap;
    baa_pkg::map_t                       front_map_next;
    logic [baa_pkg::MAG_W-1:0]           front_minor_next;
    logic [baa_pkg::MAG_W-1:0]           front_major_next;

    logic                                front_valid_reg;
    baa_pkg::map_t                       front_map_reg;
    logic [baa_pkg::MAG_W-1:0]           front_minor_reg;
    logic [baa_pkg::MAG_W-1:0]           front_major_reg;

    assign x_in       = s_tdata[18:0];
    assign y_in       = s_tdata[37:19];
    assign default_in = s_tdata[45:38];

    always_comb begin
        // Magnitudes are exact even for the most negative offset.
        ax     = x_in[baa_pkg::OFFSET_W-1] ? baa_pkg::MAG_W'(-x_in) : baa_pkg::MAG_W'(x_in);
        ay     = y_in[baa_pkg::OFFSET_W-1] ? baa_pkg::MAG_W'(-y_in) : baa_pkg::MAG_W'(y_in);
        x_zero = (x_in == '0);
        y_zero = (y_in == '0);
        x_neg  = x_in[baa_pkg::OFFSET_W-1];
        y_neg  = y_in[baa_pkg::OFFSET_W-1];
        swap   = (ax > ay);

        // The minor side over the major side keeps the ratio in 0..8192.
        front_minor_next = swap ? ay : ax;
        front_major_next = swap ? ax : ay;

        front_map_next.bypass      = 1'b0;
        front_map_next.fixed_angle = default_in;
        front_map_next.base        = baa_pkg::ANGLE_POS_X;
        front_map_next.subtract    = 1'b0;

        if (x_zero && y_zero) begin
            front_map_next.bypass = 1'b1;
        end else if (y_zero) begin
            // The vector is the negation, so a negative x points along +x.
            front_map_next.bypass      = 1'b1;
            front_map_next.fixed_angle = x_neg ? baa_pkg::ANGLE_POS_X : baa_pkg::ANGLE_NEG_X;
        end else if (x_zero) begin
            front_map_next.bypass      = 1'b1;
            front_map_next.fixed_angle = y_neg ? baa_pkg::ANGLE_POS_Y : baa_pkg::ANGLE_NEG_Y;
        end else if (x_neg && y_neg) begin
            front_map_next.base     = swap ? baa_pkg::ANGLE_POS_X : baa_pkg::ANGLE_POS_Y;
            front_map_next.subtract = !swap;
        end else if (!x_neg && y_neg) begin
            front_map_next.base     = swap ? baa_pkg::ANGLE_NEG_X : baa_pkg::ANGLE_POS_Y;
            front_map_next.subtract = swap;
        end else if (!x_neg && !y_neg) begin
            front_map_next.base     = swap ? baa_pkg::ANGLE_NEG_X : baa_pkg::ANGLE_NEG_Y;
            front_map_next.subtract = !swap;
        end else begin
            // 256 - k wraps to 0 - k in eight bits.
            front_map_next.base     = swap ? baa_pkg::ANGLE_POS_X : baa_pkg::ANGLE_NEG_Y;
            front_map_next.subtract = swap;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: one quotient bit of 8192*minor/major per stage.
    // ------------------------------------------------------------------
    logic                                div_valid_reg [baa_pkg::DIV_STAGES];
    logic [baa_pkg::REM_W-1:0]           div_rem_reg   [baa_pkg::DIV_STAGES];
    logic [baa_pkg::RATIO_W-1:0]         div_quo_reg   [baa_pkg::DIV_STAGES];
    logic [baa_pkg::MAG_W-1:0]           div_major_reg [baa_pkg::DIV_STAGES];
    baa_pkg::map_t                       div_map_reg   [baa_pkg::DIV_STAGES];

    logic [baa_pkg::REM_W-1:0]           div_rem_next  [baa_pkg::DIV_STAGES];
    logic [baa_pkg::RATIO_W-1:0]         div_quo_next  [baa_pkg::DIV_STAGES];

    always_comb begin
        logic [baa_pkg::REM_W-1:0]   trial;
        logic [baa_pkg::REM_W-1:0]   divisor;
        logic [baa_pkg::RATIO_W-1:0] quo_in;
        logic                        fits;
        for (int i = 0; i < baa_pkg::DIV_STAGES; i++) begin
            if (i == 0) begin
                // The top quotient bit is set only when minor equals major.
                trial   = {1'b0, front_minor_reg};
                divisor = {1'b0, front_major_reg};
                quo_in  = '0;
            end else begin
                // The remainder is below the divisor, so doubling fits.
                trial   = {div_rem_reg[i-1][baa_pkg::REM_W-2:0], 1'b0};
                divisor = {1'b0, div_major_reg[i-1]};
                quo_in  = div_quo_reg[i-1];
            end
            fits            = (trial >= divisor);
            div_rem_next[i] = fits ? (trial - divisor) : trial;
            div_quo_next[i] = {quo_in[baa_pkg::RATIO_W-2:0], fits};
        end
    end

    // ------------------------------------------------------------------
    // Table search: count the entries below the ratio, in four groups.
    // Entry 32 is 8192 and is never below the ratio, so it is left out.
    // ------------------------------------------------------------------
    logic [baa_pkg::GROUP_CNT_W-1:0]     cmp_cnt_next [baa_pkg::CMP_GROUPS];
    logic                                cmp_valid_reg;
    logic [baa_pkg::GROUP_CNT_W-1:0]     cmp_cnt_reg  [baa_pkg::CMP_GROUPS];
    baa_pkg::map_t                       cmp_map_reg;

    always_comb begin
        logic [baa_pkg::RATIO_W-1:0] ratio;
        ratio = div_quo_reg[baa_pkg::DIV_STAGES-1];
        for (int g = 0; g < baa_pkg::CMP_GROUPS; g++) begin
            cmp_cnt_next[g] = '0;
            for (int j = 0; j < baa_pkg::GROUP_SIZE; j++) begin
                cmp_cnt_next[g] = cmp_cnt_next[g] + baa_pkg::GROUP_CNT_W'(
                    baa_pkg::TAN_ROM[g*baa_pkg::GROUP_SIZE+j] < ratio);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sum the group counts and apply the octant mapping.
    // ------------------------------------------------------------------
    logic [baa_pkg::K_W-1:0]             k_index;
    logic [baa_pkg::ANGLE_W-1:0]         angle_next;
    logic                                m_tvalid_reg;
    logic [baa_pkg::ANGLE_W-1:0]         m_angle_reg;

    always_comb begin
        logic [baa_pkg::ANGLE_W-1:0] k_wide;
        k_index = baa_pkg::K_W'(cmp_cnt_reg[0]) + baa_pkg::K_W'(cmp_cnt_reg[1])
                + baa_pkg::K_W'(cmp_cnt_reg[2]) + baa_pkg::K_W'(cmp_cnt_reg[3]);
        k_wide  = {2'b00, k_index};
        if (cmp_map_reg.bypass) begin
            angle_next = cmp_map_reg.fixed_angle;
        end else if (cmp_map_reg.subtract) begin
            angle_next = cmp_map_reg.base - k_wide;
        end else begin
            angle_next = cmp_map_reg.base + k_wide;
        end
    end

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_angle_reg;

    // Valid bits, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
            for (int i = 0; i < baa_pkg::DIV_STAGES; i++) begin
                div_valid_reg[i] <= 1'b0;
            end
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else if (advance) begin
            front_valid_reg  <= s_tvalid;
            div_valid_reg[0] <= front_valid_reg;
            for (int i = 1; i < baa_pkg::DIV_STAGES; i++) begin
                div_valid_reg[i] <= div_valid_reg[i-1];
            end
            cmp_valid_reg <= div_valid_reg[baa_pkg::DIV_STAGES-1];
            m_tvalid_reg  <= cmp_valid_reg;
        end
    end

    // Data registers, moving with their valid bits.
    always_ff @(posedge aclk) begin
        if (advance) begin
            front_map_reg   <= front_map_next;
            front_minor_reg <= front_minor_next;
            front_major_reg <= front_major_next;

            div_major_reg[0] <= front_major_reg;
            div_map_reg[0]   <= front_map_reg;
            for (int i = 1; i < baa_pkg::DIV_STAGES; i++) begin
                div_major_reg[i] <= div_major_reg[i-1];
                div_map_reg[i]   <= div_map_reg[i-1];
            end
            for (int i = 0; i < baa_pkg::DIV_STAGES; i++) begin
                div_rem_reg[i] <= div_rem_next[i];
                div_quo_reg[i] <= div_quo_next[i];
            end

            for (int g = 0; g < baa_pkg::CMP_GROUPS; g++) begin
                cmp_cnt_reg[g] <= cmp_cnt_next[g];
            end
            cmp_map_reg <= div_map_reg[baa_pkg::DIV_STAGES-1];

            m_angle_reg <= angle_next;
        end
    end

endmodule

>>> tb/tb_binary_angle_arctangent.sv
// ============================================================================
// Binary angle arctangent testbench
// Sends offset vectors into the arctangent pipeline and checks each returned
// angle against an octant-fold and tangent-search prediction. Both stream
// sides insert random gaps and stalls, with occasional back-to-back stretches.
// ============================================================================
module tb_binary_angle_arctangent;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 550;
    localparam int MAX_GAP      = 13;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    // Truncated tan(k * 2pi / 256) in Q1.13. This is the tb's own copy so the
    // prediction does not lean on the design's table.
    localparam int TAN_Q13 [33] = '{
           0,  201,  402,  604,  806, 1010, 1215, 1421,
        1629, 1839, 2051, 2267, 2485, 2706, 2931, 3160,
        3393, 3631, 3874, 4123, 4378, 4640, 4910, 5187,
        5473, 5769, 6075, 6393, 6723, 7066, 7424, 7799,
        8192
    };

    // Every input is known from time zero.
    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // From bit 0 up: x_offset[18:0], y_offset[18:0], default_angle[7:0], zero pad[1:0].
    logic [baa_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // From bit 0 up: angle[7:0].
    logic [baa_pkg::M_TDATA_W-1:0] m_tdata;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the angle of every accepted beat and holds the
    // predictions in arrival order until the matching output beat shows up.
    // ------------------------------------------------------------------------
    class angle_scoreboard;
        logic [baa_pkg::ANGLE_W-1:0] expected_angles[$];
        int                          failures;

        function new();
            failures = 0;
        endfunction

        // Smallest table index whose entry is not below floor(8192*minor/major).
        function int tan_index(int minor, int major);
            longint ratio;
            int     k;
            ratio = (longint'(minor) <<< 13) / major;
            k     = 0;
            while (k < 32 && TAN_Q13[k] < ratio)
                k++;
            return k;
        endfunction

        // The direction is that of the negated offsets.
        function logic [baa_pkg::ANGLE_W-1:0] predict_angle(
            logic signed [baa_pkg::OFFSET_W-1:0] x_off,
            logic signed [baa_pkg::OFFSET_W-1:0] y_off,
            logic [baa_pkg::ANGLE_W-1:0]         dflt);
            int xa;
            int ya;
            int ax;
            int ay;
            int a;
            xa = -int'(x_off);
            ya = -int'(y_off);
            ax = (xa < 0) ? -xa : xa;
            ay = (ya < 0) ? -ya : ya;
            if (xa == 0 && ya == 0) begin
                return dflt;
            end else if (ya == 0) begin
                a = (xa > 0) ? 0 : 128;
            end else if (xa == 0) begin
                a = (ya > 0) ? 64 : 192;
            end else if (xa > 0 && ya > 0) begin
                a = (ax > ay) ? tan_index(ay, ax) : 64 - tan_index(ax, ay);
            end else if (xa < 0 && ya > 0) begin
                a = (ax <= ay) ? 64 + tan_index(ax, ay) : 128 - tan_index(ay, ax);
            end else if (xa < 0) begin
                a = (ax > ay) ? 128 + tan_index(ay, ax) : 192 - tan_index(ax, ay);
            end else begin
                a = (ax <= ay) ? 192 + tan_index(ax, ay) : 256 - tan_index(ay, ax);
            end
            return a[baa_pkg::ANGLE_W-1:0];
        endfunction

        function void note_offsets(logic [baa_pkg::S_TDATA_W-1:0] beat);
            expected_angles.push_back(predict_angle(beat[18:0], beat[37:19], beat[45:38]));
        endfunction

        function void fail(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        function void check_angle(logic [baa_pkg::ANGLE_W-1:0] actual);
            logic [baa_pkg::ANGLE_W-1:0] want;
            if (expected_angles.size() == 0) begin
                fail($sformatf("unexpected angle beat %0d", actual));
                return;
            end
            want = expected_angles.pop_front();
            if (actual !== want)
                fail($sformatf("angle mismatch: expected %0d, got %0d", want, actual));
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction

        function void close();
            while (expected_angles.size() != 0) begin
                fail($sformatf("angle %0d never arrived", expected_angles.pop_front()));
            end
        endfunction
    endclass

    angle_scoreboard board;

    // Burst flags switch now and then so that some stretches run with no gaps.
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    always #4 aclk = ~aclk;

    binary_angle_arctangent uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Drives one beat. It is entered right after a falling edge and returns
    // right after the falling edge that follows acceptance. With no gap the
    // valid stays high and only the data changes, so valid is never dropped
    // and raised in the same step.
    task automatic send_offsets(int x_off, int y_off, int dflt);
        int                            gap;
        logic [baa_pkg::OFFSET_W-1:0]  xv;
        logic [baa_pkg::OFFSET_W-1:0]  yv;
        logic [baa_pkg::ANGLE_W-1:0]   dv;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        xv = x_off[baa_pkg::OFFSET_W-1:0];
        yv = y_off[baa_pkg::OFFSET_W-1:0];
        dv = dflt[baa_pkg::ANGLE_W-1:0];
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, dv, yv, xv};
        do
            @(posedge aclk);
        while (!s_tready);
        board.note_offsets(s_tdata);
        @(negedge aclk);
    endtask

    // Random offset pair, shaped toward the interesting parts of the map.
    task automatic send_random();
        int kind;
        int major;
        int minor;
        int k;
        int x_off;
        int y_off;
        int picks [6];
        picks = '{-262144, -262143, -1, 0, 1, 262143};
        kind  = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                // Whole 19-bit range, the most negative code included.
                x_off = $urandom_range(0, 524287) - 262144;
                y_off = $urandom_range(0, 524287) - 262144;
            end
            4, 5: begin
                x_off = $urandom_range(0, 32) - 16;
                y_off = $urandom_range(0, 32) - 16;
            end
            6: begin
                // Close to a diagonal.
                major = $urandom_range(1, 262140);
                minor = major - $urandom_range(0, 3);
                x_off = $urandom_range(0, 1) ? major : -major;
                y_off = $urandom_range(0, 1) ? minor : -minor;
            end
            7: begin
                // On an axis.
                major = $urandom_range(1, 262144);
                x_off = $urandom_range(0, 1) ? major : -major;
                y_off = 0;
            end
            8: begin
                // Ratio lands on or right beside a table entry.
                major = $urandom_range(8192, 262143);
                k     = $urandom_range(0, 32);
                minor = int'((longint'(TAN_Q13[k]) * major) / 8192)
                        + $urandom_range(0, 2) - 1;
                if (minor > major) minor = major;
                if (minor < 1) minor = 1;
                x_off = $urandom_range(0, 1) ? major : -major;
                y_off = $urandom_range(0, 1) ? minor : -minor;
            end
            default: begin
                x_off = picks[$urandom_range(0, 5)];
                y_off = picks[$urandom_range(0, 5)];
            end
        endcase
        if ($urandom_range(0, 1))
            send_offsets(y_off, x_off, $urandom_range(0, 255));
        else
            send_offsets(x_off, y_off, $urandom_range(0, 255));
    endtask

    // Output side: a random stall before each beat, then the beat is checked
    // at the rising edge where it is taken.
    initial begin : result_sink
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do
                @(posedge aclk);
            while (!m_tvalid);
            board.check_angle(m_tdata[baa_pkg::ANGLE_W-1:0]);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int sx [4];
        int sy [4];
        int guard;
        board = new();
        sx = '{-1, 1, 1, -1};
        sy = '{-1, -1, 1, 1};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero vector returns the default angle.
        send_offsets(0, 0, 0);
        send_offsets(0, 0, 255);
        send_offsets(0, 0, 8'h5A);
        // The four axis directions.
        send_offsets(-5, 0, 3);
        send_offsets(0, -5, 3);
        send_offsets(7, 0, 3);
        send_offsets(0, 7, 3);
        // Field extremes, including the code just below the nominal range.
        send_offsets(-262144, 0, 170);
        send_offsets(0, 262143, 85);
        send_offsets(-262144, -262144, 1);
        send_offsets(262143, 262143, 2);
        send_offsets(-262144, 262143, 254);
        // Equal magnitudes in the remaining quadrants.
        send_offsets(-100, 100, 0);
        send_offsets(100, -100, 0);
        // One vector in each of the eight octants.
        for (int q = 0; q < 4; q++) begin
            send_offsets(sx[q] * 1000, sy[q] * 300, 0);
            send_offsets(sx[q] * 300, sy[q] * 1000, 0);
        end
        // Ratio exactly on a table entry and one step past it.
        send_offsets(-8192, -201, 0);
        send_offsets(-8192, -202, 0);
        send_offsets(-1, -262143, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_random();
        s_tvalid <= 1'b0;

        // Let the pipeline drain, then give it a little longer so that any
        // stray beat after the last expected one still gets caught.
        guard = 0;
        while (board.pending() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        board.close();

        if (board.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
